/* rtl/assert_macros.svh */
// Assertion helpers for the back-substitution solver.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/ubs_pkg.sv */
// ----------------------------------------------------------------------------
// ubs_pkg
// Shared types and constants of the upper-triangular back-substitution solver.
// ----------------------------------------------------------------------------
`default_nettype none

package ubs_pkg;

    localparam int MAX_N     = 16;
    localparam int IDX_W     = 4;
    localparam int N_W       = 5;
    localparam int DATA_W    = 32;
    localparam int PIVOT_W   = 31;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int PROD_W    = 64;
    localparam int TERM_W    = 48;
    localparam int ACC_W     = 52;
    localparam int NUM_W     = 53;
    localparam int DVD_W     = 63;
    localparam int DIV_STEPS = 63;
    localparam int CNT_W     = 6;

    localparam logic [1:0] OP_COEF  = 2'd0;
    localparam logic [1:0] OP_RHS   = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic CFG_SIZE  = 1'b0;
    localparam logic CFG_PIVOT = 1'b1;

    localparam logic [N_W-1:0]    SIZE_RESET  = 5'd16;
    localparam logic [PIVOT_W-1:0] PIVOT_RESET = 31'd1;
    localparam logic [DATA_W-1:0] SAT_POS     = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] SAT_NEG     = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [DATA_W-1:0] solution;
        logic [1:0]              status;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic             coef_we;
        logic             rhs_we;
        logic             acc_clr;
        logic             mul_load;
        logic             acc_add;
        logic             diag_load;
        logic             div_start;
        logic             div_step;
        logic             sol_we;
        logic             out_load;
        logic             out_sing;
        logic             out_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic singular;
        logic out_full;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/upper_triangular_back_substitution_top.sv */
// ----------------------------------------------------------------------------
// upper_triangular_back_substitution_top
// Solves U x = b, U upper triangular, in signed Q16.16.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item): op 0 loads U[row][col], op 1
// loads b[row], op 2 solves; op 3 is dropped. in_ready stays high between
// solves, so loads stream at one word a cycle. A solve holds in_ready low
// until its last result is loaded in the output register. Each row runs a
// coefficient RAM read, multiply and accumulate per off-diagonal term, then
// the diagonal read and the 63-step restoring divider; once every row is
// solved, x[0..n-1] are emitted in order, last on x[n-1].
// A singular diagonal ends the solve with one result of status 1.
// Output channel (out_valid/out_ready/out_item) is a single register; when
// the receiver stalls, the word holds and emission waits.
// Configuration (cfg_we/cfg_index/cfg_data): index 0 size_in_use, index 1
// pivot_min; write only while idle. Reset sets size 16, pivot_min 1 and
// empties the output register; the stores are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module upper_triangular_back_substitution_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire ubs_pkg::in_item_t           in_item,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output ubs_pkg::out_item_t               out_item,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [ubs_pkg::PIVOT_W-1:0] cfg_data
);

    ubs_pkg::cmd_t  cmd;
    ubs_pkg::stat_t stat;

    ubs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_size  (cfg_data[ubs_pkg::N_W-1:0]),
        .cmd       (cmd),
        .stat      (stat)
    );

    ubs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_pivot (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`include "assert_macros.svh"

    `CHK_NOW(a_no_overwrite, cmd.out_load, !stat.out_full)
    `CHK_NOW(a_load_on_accept, cmd.coef_we || cmd.rhs_we, in_valid && in_ready)
    `CHK_NEXT(a_solve_busy, in_valid && in_ready && in_item.op == ubs_pkg::OP_SOLVE, !in_ready)

endmodule

`default_nettype wire

/* rtl/ubs_ram.sv */
// ----------------------------------------------------------------------------
// ubs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ubs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/ubs_ctrl.sv */
// ----------------------------------------------------------------------------
// ubs_ctrl
// Solve sequencer: row/column counters, divider step count, result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ubs_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ubs_pkg::in_item_t      in_item,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [ubs_pkg::N_W-1:0] cfg_size,
    output ubs_pkg::cmd_t               cmd,
    input  wire ubs_pkg::stat_t         stat
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_MAC_RD  = 11'b000_0000_0010,
        S_MAC_MUL = 11'b000_0000_0100,
        S_MAC_ACC = 11'b000_0000_1000,
        S_DG_RD   = 11'b000_0001_0000,
        S_DG_LAT  = 11'b000_0010_0000,
        S_DG_DEC  = 11'b000_0100_0000,
        S_DIV     = 11'b000_1000_0000,
        S_SOL_WR  = 11'b001_0000_0000,
        S_SING    = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [ubs_pkg::N_W-1:0]       size_reg;
    logic [ubs_pkg::N_W-1:0]       n_reg, n_next;
    logic [ubs_pkg::IDX_W-1:0]     i_reg, i_next;
    logic [ubs_pkg::N_W-1:0]       j_reg, j_next;
    logic [ubs_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ubs_pkg::N_W-1:0]       n_eff;
    logic                          accept;
    logic                          row_last;

    // Clamp the configured size to 1..MAX_N.
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = ubs_pkg::N_W'(1);
        end
        else if (size_reg > ubs_pkg::N_W'(ubs_pkg::MAX_N))
        begin
            n_eff = ubs_pkg::N_W'(ubs_pkg::MAX_N);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign row_last = ({1'b0, i_reg} == (n_reg - ubs_pkg::N_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= ubs_pkg::SIZE_RESET;
        end
        else if (cfg_we && cfg_index == ubs_pkg::CFG_SIZE)
        begin
            size_reg <= cfg_size;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.row    = i_reg;
        cmd.col    = j_reg[ubs_pkg::IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.coef_we = (in_item.op == ubs_pkg::OP_COEF);
                    cmd.rhs_we  = (in_item.op == ubs_pkg::OP_RHS);
                    if (in_item.op == ubs_pkg::OP_SOLVE)
                    begin
                        n_next      = n_eff;
                        i_next      = ubs_pkg::IDX_W'(n_eff - ubs_pkg::N_W'(1));
                        j_next      = n_eff;
                        cmd.acc_clr = 1'b1;
                        state_next  = S_DG_RD;
                    end
                end
            end
            S_MAC_RD:
            begin
                state_next = S_MAC_MUL;
            end
            S_MAC_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MAC_ACC;
            end
            S_MAC_ACC:
            begin
                cmd.acc_add = 1'b1;
                j_next      = j_reg + ubs_pkg::N_W'(1);
                if ((j_reg + ubs_pkg::N_W'(1)) == n_reg)
                begin
                    state_next = S_DG_RD;
                end
                else
                begin
                    state_next = S_MAC_RD;
                end
            end
            S_DG_RD:
            begin
                cmd.col    = i_reg;
                state_next = S_DG_LAT;
            end
            S_DG_LAT:
            begin
                cmd.col       = i_reg;
                cmd.diag_load = 1'b1;
                state_next    = S_DG_DEC;
            end
            S_DG_DEC:
            begin
                if (stat.singular)
                begin
                    state_next = S_SING;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + ubs_pkg::CNT_W'(1);
                if (cnt_reg == ubs_pkg::CNT_W'(ubs_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_SOL_WR;
                end
            end
            S_SOL_WR:
            begin
                cmd.sol_we = 1'b1;
                if (i_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    // Next row up; its first term is the row just solved.
                    i_next      = i_reg - ubs_pkg::IDX_W'(1);
                    j_next      = {1'b0, i_reg};
                    cmd.acc_clr = 1'b1;
                    state_next  = S_MAC_RD;
                end
            end
            S_SING:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sing = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EMIT:
            begin
                cmd.col = i_reg;
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = row_last;
                    if (row_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + ubs_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= ubs_pkg::SIZE_RESET;
            i_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ubs_dp.sv */
// ----------------------------------------------------------------------------
// ubs_dp
// Solver datapath: stores, multiply-accumulate, restoring divider, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module ubs_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ubs_pkg::in_item_t           in_item,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [ubs_pkg::PIVOT_W-1:0] cfg_pivot,
    input  wire ubs_pkg::cmd_t               cmd,
    output ubs_pkg::stat_t                   stat,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output ubs_pkg::out_item_t               out_item
);

    logic [ubs_pkg::DATA_W-1:0]         ram_q;
    logic [ubs_pkg::DATA_W-1:0]         rhs_reg [ubs_pkg::MAX_N];
    logic [ubs_pkg::DATA_W-1:0]         sol_reg [ubs_pkg::MAX_N];
    logic [ubs_pkg::MAX_N-1:0]          sat_reg;
    logic [ubs_pkg::PIVOT_W-1:0]        pivot_reg;
    logic signed [ubs_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ubs_pkg::PROD_W-1:0]  prod_rnd;
    logic [ubs_pkg::TERM_W-1:0]         term;
    logic [ubs_pkg::ACC_W-1:0]          acc_reg;
    logic [ubs_pkg::DATA_W-1:0]         diag_reg;
    logic [ubs_pkg::NUM_W-1:0]          num_reg;
    logic [ubs_pkg::NUM_W-1:0]          num_mag;
    logic [ubs_pkg::DATA_W-1:0]         dmag;
    logic [ubs_pkg::DATA_W-1:0]         dmag_reg;
    logic                               neg_reg;
    logic                               presat_reg;
    logic [ubs_pkg::DVD_W-1:0]          dvd_reg;
    logic [ubs_pkg::DATA_W-1:0]         rem_reg;
    logic [ubs_pkg::DATA_W:0]           rem_sh;
    logic [ubs_pkg::DATA_W:0]           rem_diff;
    logic                               rem_ge;
    logic [ubs_pkg::DATA_W-1:0]         sol_rd;
    logic [ubs_pkg::DATA_W-1:0]         rhs_rd;
    logic [ubs_pkg::DATA_W-1:0]         q_val;
    logic                               q_sat;
    logic                               out_valid_reg;
    ubs_pkg::out_item_t                 out_reg;

    ubs_ram #(
        .WIDTH (ubs_pkg::DATA_W),
        .DEPTH (ubs_pkg::MAX_N * ubs_pkg::MAX_N)
    ) u_coef_ram (
        .clk     (clk),
        .we      (cmd.coef_we),
        .wr_addr ({in_item.row, in_item.col}),
        .wr_data (in_item.value),
        .rd_addr ({cmd.row, cmd.col}),
        .rd_data (ram_q)
    );

    assign sol_rd = sol_reg[cmd.col];
    assign rhs_rd = rhs_reg[cmd.row];

    // Round product to Q16.16: nearest, ties toward plus infinity.
    assign prod_rnd = prod_reg + ubs_pkg::PROD_W'(32768);
    assign term     = prod_rnd[ubs_pkg::PROD_W-1:16];

    assign num_mag  = num_reg[ubs_pkg::NUM_W-1] ? (~num_reg + ubs_pkg::NUM_W'(1)) : num_reg;
    assign dmag     = diag_reg[ubs_pkg::DATA_W-1] ? (~diag_reg + ubs_pkg::DATA_W'(1))
                                                  : diag_reg;
    assign stat.singular = (diag_reg == '0) || (dmag < {1'b0, pivot_reg});
    assign stat.out_full = out_valid_reg && !out_ready;

    // One restoring division step per cycle.
    assign rem_sh   = {rem_reg, dvd_reg[ubs_pkg::DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dmag_reg};
    assign rem_ge   = (rem_sh >= {1'b0, dmag_reg});

    // Apply sign and saturate the finished quotient.
    always_comb
    begin
        q_sat = 1'b0;
        q_val = dvd_reg[ubs_pkg::DATA_W-1:0];
        if (presat_reg)
        begin
            q_sat = 1'b1;
            q_val = neg_reg ? ubs_pkg::SAT_NEG : ubs_pkg::SAT_POS;
        end
        else if (neg_reg)
        begin
            if ((|dvd_reg[ubs_pkg::DVD_W-1:ubs_pkg::DATA_W])
                || (dvd_reg[ubs_pkg::DATA_W-1] && (|dvd_reg[ubs_pkg::DATA_W-2:0])))
            begin
                q_sat = 1'b1;
                q_val = ubs_pkg::SAT_NEG;
            end
            else
            begin
                q_val = ~dvd_reg[ubs_pkg::DATA_W-1:0] + ubs_pkg::DATA_W'(1);
            end
        end
        else if (|dvd_reg[ubs_pkg::DVD_W-1:ubs_pkg::DATA_W-1])
        begin
            q_sat = 1'b1;
            q_val = ubs_pkg::SAT_POS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_reg <= ubs_pkg::PIVOT_RESET;
        end
        else if (cfg_we && cfg_index == ubs_pkg::CFG_PIVOT)
        begin
            pivot_reg <= cfg_pivot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rhs_we)
        begin
            rhs_reg[in_item.row] <= in_item.value;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= $signed(ram_q) * $signed(sol_rd);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg
                     + {{(ubs_pkg::ACC_W - ubs_pkg::TERM_W){term[ubs_pkg::TERM_W-1]}}, term};
        end
        if (cmd.diag_load)
        begin
            diag_reg <= ram_q;
            num_reg  <= {{(ubs_pkg::NUM_W - ubs_pkg::DATA_W){rhs_rd[ubs_pkg::DATA_W-1]}}, rhs_rd}
                      - {acc_reg[ubs_pkg::ACC_W-1], acc_reg};
        end
        if (cmd.div_start)
        begin
            dmag_reg   <= dmag;
            neg_reg    <= num_reg[ubs_pkg::NUM_W-1] ^ diag_reg[ubs_pkg::DATA_W-1];
            presat_reg <= |num_mag[ubs_pkg::NUM_W-1:47];
            dvd_reg    <= {num_mag[46:0], 16'h0000};
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_diff[ubs_pkg::DATA_W-1:0] : rem_sh[ubs_pkg::DATA_W-1:0];
            dvd_reg <= {dvd_reg[ubs_pkg::DVD_W-2:0], rem_ge};
        end
        if (cmd.sol_we)
        begin
            sol_reg[cmd.row] <= q_val;
            sat_reg[cmd.row] <= q_sat;
        end
        if (cmd.out_load)
        begin
            out_reg.index    <= cmd.row;
            out_reg.solution <= cmd.out_sing ? '0 : sol_rd;
            out_reg.last     <= cmd.out_last;
            if (cmd.out_sing)
            begin
                out_reg.status <= ubs_pkg::ST_SING;
            end
            else
            begin
                out_reg.status <= sat_reg[cmd.col] ? ubs_pkg::ST_SAT : ubs_pkg::ST_OK;
            end
        end
    end

    // Hold the word until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire
